### hw/rtl/m3inv_pkg.sv
// Shared types and constants for the 3x3 matrix inverse unit.
// No dependencies.
`default_nettype none
package m3inv_pkg;
  localparam int ElemW   = 32;
  localparam int CofW    = 66;
  localparam int DetW    = 98;
  localparam int QDepth  = 4;
  localparam int FracW   = 16;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [CofW-1:0]  cof_t;
  typedef logic signed [DetW-1:0]  det_t;

  typedef struct packed {
    cof_t [8:0] cof;
    det_t       det;
  } job_t;
endpackage
`default_nettype wire

### hw/rtl/matrix3_inverse_unit.sv
// 3x3 matrix inverse by adjugate, Q16.16. Front, queue and back end are pipelined;
// one request accepted per clock, busy is held low.
// Front computes cofactors and determinant, a 4-entry queue decouples it
// from the back end (abs, numerator, overflow check, 33-step divider).
// The receiver cannot stall.
// Reset (rst_n, synchronous) clears all valid bits and the queue pointers.
`default_nettype none
module matrix3_inverse_unit import m3inv_pkg::*; #(
  parameter int QueueDepth = QDepth
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire elem_t in_col0_row0, input wire elem_t in_col0_row1,
  input  wire elem_t in_col0_row2, input wire elem_t in_col1_row0,
  input  wire elem_t in_col1_row1, input wire elem_t in_col1_row2,
  input  wire elem_t in_col2_row0, input wire elem_t in_col2_row1,
  input  wire elem_t in_col2_row2,
  output logic  out_strobe,
  output elem_t out_inv_col0_row0, output elem_t out_inv_col0_row1,
  output elem_t out_inv_col0_row2, output elem_t out_inv_col1_row0,
  output elem_t out_inv_col1_row1, output elem_t out_inv_col1_row2,
  output elem_t out_inv_col2_row0, output elem_t out_inv_col2_row1,
  output elem_t out_inv_col2_row2,
  output logic  out_invertible
);
  logic take, jv, qne;
  job_t fj, qj;
  elem_t [8:0] q;

  // back end never stalls, so queue drains every cycle: never fills
  assign busy = 1'b0;
  assign take = start && !busy;

  m3inv_front u_front (.clk, .rst_n, .take,
    .m({in_col2_row2, in_col2_row1, in_col2_row0, in_col1_row2, in_col1_row1,
        in_col1_row0, in_col0_row2, in_col0_row1, in_col0_row0}),
    .job_vld(jv), .job(fj));

  m3inv_queue #(.Depth(QueueDepth)) u_queue (.clk, .rst_n, .push(jv), .din(fj),
    .pop(qne), .nempty(qne), .dout(qj));

  m3inv_back u_back (.clk, .rst_n, .in_vld(qne), .job(qj), .out_vld(out_strobe),
    .out_q(q), .out_ok(out_invertible));

  assign {out_inv_col2_row2, out_inv_col2_row1, out_inv_col2_row0,
          out_inv_col1_row2, out_inv_col1_row1, out_inv_col1_row0,
          out_inv_col0_row2, out_inv_col0_row1, out_inv_col0_row0} = q;
endmodule
`default_nettype wire

### hw/rtl/m3inv_front.sv
// Front end: cofactors (stage 1) and determinant (stage 2 and 3) of each request.
// Depends on m3inv_pkg.
`default_nettype none
module m3inv_front import m3inv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire elem_t [8:0] m,
  output logic             job_vld,
  output job_t             job
);
  logic [2:0] vld_r;
  cof_t [8:0] cof1_r, cof2_r, cof3_r;
  elem_t [2:0] c0_r;
  // cofactor split at bit 32: signed high part and unsigned low part products
  logic signed [65:0] pph_r [3];
  logic signed [64:0] ppl_r [3];
  det_t det_r;

  function automatic cof_t cf(elem_t a, elem_t b, elem_t c, elem_t d);
    logic signed [63:0] p, q;
    p = a * b;
    q = c * d;
    return CofW'(p) - CofW'(q);
  endfunction

  always_ff @(posedge clk) begin
    det_t acc;
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[1:0], take};
    cof1_r[0] <= cf(m[4], m[8], m[7], m[5]);
    cof1_r[1] <= cf(m[7], m[2], m[1], m[8]);
    cof1_r[2] <= cf(m[1], m[5], m[4], m[2]);
    cof1_r[3] <= cf(m[6], m[5], m[3], m[8]);
    cof1_r[4] <= cf(m[0], m[8], m[6], m[2]);
    cof1_r[5] <= cf(m[3], m[2], m[0], m[5]);
    cof1_r[6] <= cf(m[3], m[7], m[4], m[6]);
    cof1_r[7] <= cf(m[6], m[1], m[0], m[7]);
    cof1_r[8] <= cf(m[0], m[4], m[3], m[1]);
    c0_r      <= {m[6], m[3], m[0]};
    for (int k = 0; k < 3; k++) begin
      pph_r[k] <= $signed(cof1_r[k][CofW-1:32]) * c0_r[k];
      ppl_r[k] <= $signed({1'b0, cof1_r[k][31:0]}) * c0_r[k];
    end
    cof2_r <= cof1_r;
    acc = '0;
    for (int k = 0; k < 3; k++)
      acc = acc + (DetW'(pph_r[k]) << 32) + DetW'(ppl_r[k]);
    det_r  <= acc;
    cof3_r <= cof2_r;
  end

  assign job_vld = vld_r[2];
  assign job.cof = cof3_r;
  assign job.det = det_r;
endmodule
`default_nettype wire

### hw/rtl/m3inv_queue.sv
// Short FIFO between front and back ends.
// Depends on m3inv_pkg.
`default_nettype none
module m3inv_queue import m3inv_pkg::*; #(
  parameter int Depth = QDepth
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t din,
  input  wire logic pop,
  output logic      nempty,
  output job_t      dout
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  job_t mem_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem_r[wp_r] <= din;
  end
  assign nempty = cnt_r != '0;
  assign dout   = mem_r[rp_r];
endmodule
`default_nettype wire

### hw/rtl/m3inv_back.sv
// Back end: pipelined rounded division cofactor*2^32/det, nine lanes, saturation.
// Depends on m3inv_pkg.
`default_nettype none
module m3inv_back import m3inv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_vld,
  input  wire job_t        job,
  output logic             out_vld,
  output elem_t      [8:0] out_q,
  output logic             out_ok
);
  // Quotients below 2^33 are resolved bit by bit; anything larger saturates.
  localparam int QW = 33;
  localparam int RW = DetW + 1;  // divisor 2|det| and partial remainder
  localparam int NS = QW + 3;    // abs, numerator, overflow check, QW steps

  logic [NS-1:0] vld_r;

  // absolute values
  logic            zero_a_r;
  logic [8:0]      neg_a_r;
  logic [DetW-1:0] ad_a_r;
  logic [CofW-1:0] ac_a_r [9];

  // numerator = |c|*2^33 + |d|: high part |c| + |d|>>33, low 33 bits of |d|
  logic            zero_b_r;
  logic [8:0]      neg_b_r;
  logic [RW-1:0]   den_b_r;
  logic [QW-1:0]   lo_b_r;
  logic [RW-1:0]   hi_b_r [9];

  // divider stages
  logic [QW:0]     zero_r;
  logic [8:0]      neg_r [QW+1];
  logic [8:0]      ovf_r [QW+1];
  logic [RW-1:0]   den_r [QW];
  logic [QW-1:0]   lo_r  [QW];
  logic [RW-1:0]   rem_r [QW][9];
  logic [QW-1:0]   quo_r [QW+1][9];

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [RW:0] div_step(logic [RW-1:0] rem, logic nb,
                                           logic [RW-1:0] den);
    logic [RW-1:0] r;
    r = {rem[RW-2:0], nb};
    if (r >= den) return {1'b1, r - den};
    return {1'b0, r};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[NS-2:0], in_vld};
  end

  always_ff @(posedge clk) begin
    logic [RW:0] st;
    zero_a_r <= job.det == '0;
    ad_a_r   <= job.det[DetW-1] ? DetW'(-job.det) : DetW'(job.det);
    for (int k = 0; k < 9; k++) begin
      neg_a_r[k] <= job.cof[k][CofW-1] ^ job.det[DetW-1];
      ac_a_r[k]  <= job.cof[k][CofW-1] ? CofW'(-job.cof[k]) : CofW'(job.cof[k]);
    end

    zero_b_r <= zero_a_r;
    neg_b_r  <= neg_a_r;
    den_b_r  <= {ad_a_r, 1'b0};
    lo_b_r   <= ad_a_r[QW-1:0];
    for (int k = 0; k < 9; k++)
      hi_b_r[k] <= RW'(ac_a_r[k]) + RW'(ad_a_r[DetW-1:QW]);

    // high part at or above the divisor: quotient >= 2^33, saturates
    zero_r[0] <= zero_b_r;
    neg_r[0]  <= neg_b_r;
    den_r[0]  <= den_b_r;
    lo_r[0]   <= lo_b_r;
    for (int k = 0; k < 9; k++) begin
      ovf_r[0][k] <= hi_b_r[k] >= den_b_r;
      rem_r[0][k] <= hi_b_r[k];
      quo_r[0][k] <= '0;
    end

    for (int j = 0; j < QW; j++) begin
      zero_r[j+1] <= zero_r[j];
      neg_r[j+1]  <= neg_r[j];
      ovf_r[j+1]  <= ovf_r[j];
    end
    for (int j = 0; j < QW-1; j++) begin
      den_r[j+1] <= den_r[j];
      lo_r[j+1]  <= lo_r[j];
      for (int k = 0; k < 9; k++) begin
        st = div_step(rem_r[j][k], lo_r[j][QW-1-j], den_r[j]);
        rem_r[j+1][k] <= st[RW-1:0];
        quo_r[j+1][k] <= {quo_r[j][k][QW-2:0], st[RW]};
      end
    end
    // last step only needs the quotient bit
    for (int k = 0; k < 9; k++) begin
      st = div_step(rem_r[QW-1][k], lo_r[QW-1][0], den_r[QW-1]);
      quo_r[QW][k] <= {quo_r[QW-1][k][QW-2:0], st[RW]};
    end
  end

  always_comb begin
    out_vld = vld_r[NS-1];
    out_ok  = !zero_r[QW];
    for (int k = 0; k < 9; k++) begin
      if (zero_r[QW]) out_q[k] = '0;
      else if (!neg_r[QW][k])
        out_q[k] = (ovf_r[QW][k] || quo_r[QW][k] > QW'(32'h7FFFFFFF)) ?
                   32'sh7FFFFFFF : elem_t'(quo_r[QW][k][31:0]);
      else
        out_q[k] = (ovf_r[QW][k] || quo_r[QW][k] > QW'(32'h80000000)) ?
                   32'sh80000000 : elem_t'(-quo_r[QW][k][31:0]);
    end
  end
endmodule
`default_nettype wire

### hw/rtl/m3inv_checker.sv
// Port-level checks for matrix3_inverse_unit, bound to the top level.
// Depends on m3inv_pkg.
`default_nettype none
module m3inv_checker import m3inv_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  input wire logic  busy,
  input wire logic  out_strobe,
  input wire logic  out_invertible,
  input wire elem_t out_inv_col0_row0,
  input wire elem_t out_inv_col1_row1
);
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_invertible |-> out_inv_col0_row0 == '0 && out_inv_col1_row1 == '0)
    else $error("singular result not zero");
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy asserted");
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("strobe after reset");
endmodule

bind matrix3_inverse_unit m3inv_checker u_chk (.clk, .rst_n, .busy, .out_strobe,
  .out_invertible, .out_inv_col0_row0, .out_inv_col1_row1);
`default_nettype wire
